// ===== hdl/tar_pkg.sv =====
// Package for the register ALU unit: operation codes and operand/result bundles.
// Used by tar_shift, tar_alu and thumb_alu_register_ops_unit; no dependencies.
package tar_pkg;

    typedef enum logic [3:0] {
        OP_AND = 4'd0,
        OP_EOR = 4'd1,
        OP_LSL = 4'd2,
        OP_LSR = 4'd3,
        OP_ASR = 4'd4,
        OP_ADC = 4'd5,
        OP_SBC = 4'd6,
        OP_ROR = 4'd7,
        OP_TST = 4'd8,
        OP_NEG = 4'd9,
        OP_CMP = 4'd10,
        OP_CMN = 4'd11,
        OP_ORR = 4'd12,
        OP_MUL = 4'd13,
        OP_BIC = 4'd14,
        OP_MVN = 4'd15
    } t_alu_op;

    localparam int unsigned WORD_W  = 32;
    localparam int unsigned AMT_W   = 8;
    localparam int unsigned SHAMT_W = 5;

    typedef struct packed {
        t_alu_op             op;
        logic [WORD_W-1:0]   dest_value;
        logic [WORD_W-1:0]   source_value;
        logic                carry_in;
        logic                overflow_in;
    } t_alu_in;

    typedef struct packed {
        logic [WORD_W-1:0]   result;
        logic                write_back;
        logic                flag_negative;
        logic                flag_zero;
        logic                flag_carry;
        logic                flag_overflow;
    } t_alu_out;

    typedef struct packed {
        logic [WORD_W-1:0]   result;
        logic                carry;
    } t_shift_res;

endpackage

// ===== hdl/tar_if.sv =====
// Valid/ready channel interfaces for the register ALU unit: operand and result transfers.
// No dependencies.
interface tar_in_if;
    logic        valid;
    logic        ready;
    logic [3:0]  operation;
    logic [31:0] dest_value;
    logic [31:0] source_value;
    logic        carry_in;
    logic        overflow_in;

    modport source (output valid, operation, dest_value, source_value, carry_in, overflow_in,
                    input ready);
    modport sink   (input valid, operation, dest_value, source_value, carry_in, overflow_in,
                    output ready);
endinterface

interface tar_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] result;
    logic        write_back;
    logic        flag_negative;
    logic        flag_zero;
    logic        flag_carry;
    logic        flag_overflow;

    modport source (output valid, result, write_back, flag_negative, flag_zero, flag_carry,
                    flag_overflow, input ready);
    modport sink   (input valid, result, write_back, flag_negative, flag_zero, flag_carry,
                    flag_overflow, output ready);
endinterface

// ===== hdl/thumb_alu_register_ops_unit.sv =====
// Top level of the register ALU unit: operand register, execute logic, result register.
// Depends on tar_pkg, tar_in_if, tar_out_if and tar_alu.
//
//  channel  | dir | handshake      | payload
//  ---------+-----+----------------+-----------------------------------------------
//  i_in     | in  | valid / ready  | operation, dest_value, source_value, carry_in,
//           |     |                | overflow_in
//  o_out    | out | valid / ready  | result, write_back, flag_negative, flag_zero,
//           |     |                | flag_carry, flag_overflow
//
// Each item passes the operand register and then the result register; one item per cycle
// sustained while the output is ready.
// The 32x32 low-word multiplier and the 33-bit adder set the execute path between the registers.
// Reset (synchronous, active low) empties both registers; no result is pending after it.
// A stalled output holds its result; the operand register keeps filling until both are full.
module thumb_alu_register_ops_unit
    import tar_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    tar_in_if.sink        i_in,
    tar_out_if.source     o_out
);

    logic     r_in_valid;
    t_alu_in  r_in;
    logic     r_out_valid;
    t_alu_out r_out;
    t_alu_out n_out;
    logic     advance;

    assign advance    = !r_out_valid || o_out.ready;
    assign i_in.ready = !r_in_valid || advance;

    tar_alu u_alu (
        .i_in  (r_in),
        .o_out (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in.op           <= t_alu_op'(i_in.operation);
            r_in.dest_value   <= i_in.dest_value;
            r_in.source_value <= i_in.source_value;
            r_in.carry_in     <= i_in.carry_in;
            r_in.overflow_in  <= i_in.overflow_in;
        end
        if (advance && r_in_valid) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.result        = r_out.result;
    assign o_out.write_back    = r_out.write_back;
    assign o_out.flag_negative = r_out.flag_negative;
    assign o_out.flag_zero     = r_out.flag_zero;
    assign o_out.flag_carry    = r_out.flag_carry;
    assign o_out.flag_overflow = r_out.flag_overflow;

    a_hold_operand: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> (r_in_valid && $stable(r_in)))
        else $error("operand register lost its item during a stall");

    a_move_to_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && advance) |=> r_out_valid)
        else $error("operand item did not reach the result register");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_in_valid && advance) |=> !r_out_valid)
        else $error("result valid without a source item");

endmodule

// ===== hdl/tar_shift.sv =====
// Barrel shifter for LSL, LSR, ASR and ROR with carry-out.
// Depends on tar_pkg.
module tar_shift
    import tar_pkg::*;
(
    input  t_alu_op             i_op,
    input  logic [WORD_W-1:0]   i_value,
    input  logic [AMT_W-1:0]    i_amount,
    input  logic                i_carry,
    output t_shift_res          o_res
);

    logic [SHAMT_W-1:0] k;
    logic               amt_zero;
    logic               amt_word;
    logic               amt_over;
    logic [WORD_W:0]    lsl_w;
    logic [WORD_W:0]    lsr_w;
    logic [WORD_W:0]    asr_w;
    logic [2*WORD_W-1:0] ror_w;
    logic               sign;

    assign k        = i_amount[SHAMT_W-1:0];
    assign amt_zero = (i_amount == '0);
    assign amt_word = (i_amount == AMT_W'(WORD_W));
    assign amt_over = (i_amount > AMT_W'(WORD_W));
    assign sign     = i_value[WORD_W-1];
    assign lsl_w    = {1'b0, i_value} << k;
    assign lsr_w    = {i_value, 1'b0} >> k;
    assign asr_w    = (WORD_W+1)'($signed({i_value, 1'b0}) >>> k);
    assign ror_w    = {i_value, i_value} >> k;

    always_comb begin
        o_res.result = i_value;
        o_res.carry  = i_carry;
        if (!amt_zero) begin
            case (i_op)
                OP_LSL: begin
                    if (amt_word) begin
                        o_res.result = '0;
                        o_res.carry  = i_value[0];
                    end else if (amt_over) begin
                        o_res.result = '0;
                        o_res.carry  = 1'b0;
                    end else begin
                        o_res.result = lsl_w[WORD_W-1:0];
                        o_res.carry  = lsl_w[WORD_W];
                    end
                end
                OP_LSR: begin
                    if (amt_word) begin
                        o_res.result = '0;
                        o_res.carry  = sign;
                    end else if (amt_over) begin
                        o_res.result = '0;
                        o_res.carry  = 1'b0;
                    end else begin
                        o_res.result = lsr_w[WORD_W:1];
                        o_res.carry  = lsr_w[0];
                    end
                end
                OP_ASR: begin
                    if (amt_word || amt_over) begin
                        o_res.result = {WORD_W{sign}};
                        o_res.carry  = sign;
                    end else begin
                        o_res.result = asr_w[WORD_W:1];
                        o_res.carry  = asr_w[0];
                    end
                end
                OP_ROR: begin
                    o_res.result = ror_w[WORD_W-1:0];
                    o_res.carry  = ror_w[WORD_W-1];
                end
                default: begin
                    o_res.result = i_value;
                    o_res.carry  = i_carry;
                end
            endcase
        end
    end

endmodule

// ===== hdl/tar_alu.sv =====
// Combinational execute logic: logic ops, shared adder, multiplier and flag generation.
// Depends on tar_pkg and tar_shift.
module tar_alu
    import tar_pkg::*;
(
    input  t_alu_in   i_in,
    output t_alu_out  o_out
);

    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    logic [WORD_W-1:0] add_x;
    logic [WORD_W-1:0] add_y;
    logic              add_cin;
    logic [WORD_W:0]   sum;
    logic              add_v;
    logic [WORD_W-1:0] prod;
    logic [WORD_W-1:0] res;
    logic              c_new;
    logic              v_new;
    logic              wb;
    t_shift_res        sh;

    assign a = i_in.dest_value;
    assign b = i_in.source_value;

    tar_shift u_shift (
        .i_op     (i_in.op),
        .i_value  (a),
        .i_amount (b[AMT_W-1:0]),
        .i_carry  (i_in.carry_in),
        .o_res    (sh)
    );

    always_comb begin
        add_x   = (i_in.op == OP_NEG) ? '0 : a;
        add_y   = (i_in.op inside {OP_SBC, OP_CMP, OP_NEG}) ? ~b : b;
        add_cin = 1'b0;
        if (i_in.op inside {OP_ADC, OP_SBC}) begin
            add_cin = i_in.carry_in;
        end else if (i_in.op inside {OP_CMP, OP_NEG}) begin
            add_cin = 1'b1;
        end
    end

    assign sum   = {1'b0, add_x} + {1'b0, add_y} + (WORD_W+1)'(add_cin);
    assign add_v = ~(add_x[WORD_W-1] ^ add_y[WORD_W-1]) & (add_x[WORD_W-1] ^ sum[WORD_W-1]);
    assign prod  = a * b;

    always_comb begin
        res   = '0;
        c_new = i_in.carry_in;
        v_new = i_in.overflow_in;
        wb    = 1'b1;
        case (i_in.op)
            OP_AND: res = a & b;
            OP_EOR: res = a ^ b;
            OP_LSL, OP_LSR, OP_ASR, OP_ROR: begin
                res   = sh.result;
                c_new = sh.carry;
            end
            OP_ADC, OP_SBC, OP_NEG: begin
                res   = sum[WORD_W-1:0];
                c_new = sum[WORD_W];
                v_new = add_v;
            end
            OP_TST: begin
                res = a & b;
                wb  = 1'b0;
            end
            OP_CMP, OP_CMN: begin
                res   = sum[WORD_W-1:0];
                c_new = sum[WORD_W];
                v_new = add_v;
                wb    = 1'b0;
            end
            OP_ORR: res = a | b;
            OP_MUL: res = prod;
            OP_BIC: res = a & ~b;
            OP_MVN: res = ~b;
            default: res = ~b;
        endcase
    end

    assign o_out.result        = res;
    assign o_out.write_back    = wb;
    assign o_out.flag_negative = res[WORD_W-1];
    assign o_out.flag_zero     = (res == '0);
    assign o_out.flag_carry    = c_new;
    assign o_out.flag_overflow = v_new;

endmodule

// ===== dv/tb_thumb_alu_register_ops_unit.sv =====
// Testbench for thumb_alu_register_ops_unit: directed and random ALU operations with
// random idling on both channels, checked against an in-bench model of the sixteen ops.
// Depends on tar_pkg, tar_in_if, tar_out_if and the unit itself.
module tb_thumb_alu_register_ops_unit;
    import tar_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned RANDOM_ITEMS = 1950;
    localparam int unsigned TAIL_ITEMS   = 150;
    localparam int unsigned DRAIN_EVERY  = 400;
    localparam int unsigned CYCLE_LIMIT  = 500000;
    localparam int unsigned SETTLE_CYCLES = 8;

    typedef struct {
        t_alu_in     operands;
        int unsigned gap;
        bit          drain;
    } t_alu_request;

    logic i_clk = 1'b0;
    logic i_rst_n;

    tar_in_if  u_in_if ();
    tar_out_if u_out_if ();

    thumb_alu_register_ops_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (u_in_if),
        .o_out   (u_out_if)
    );

    always #6 i_clk = ~i_clk;

    t_alu_request pending_q[$];
    t_alu_out     alu_results_due[$];
    t_alu_request staged;
    t_alu_in      in_flight;
    bit           have_staged = 1'b0;
    int unsigned  transfers_in = 0;
    int unsigned  results_checked = 0;
    int unsigned  fail_count = 0;
    int unsigned  cycle_count = 0;
    int unsigned  stall_left = 0;
    int unsigned  stall_mode = 0;
    logic [15:0]  ops_seen = '0;

    function automatic logic [33:0] add_with_carry(logic [31:0] a, logic [31:0] b, logic cin);
        logic [32:0] sum;
        logic        ovf;
        sum = {1'b0, a} + {1'b0, b} + {32'd0, cin};
        ovf = (a[31] == b[31]) && (sum[31] != a[31]);
        return {ovf, sum};
    endfunction

    function automatic t_alu_out execute_alu_op(t_alu_in x);
        t_alu_out    o;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] r;
        logic [33:0] sum;
        logic [7:0]  amt;
        logic [4:0]  rot;
        logic        c;
        logic        v;
        logic        wb;
        a   = x.dest_value;
        b   = x.source_value;
        c   = x.carry_in;
        v   = x.overflow_in;
        wb  = 1'b1;
        amt = b[7:0];
        r   = '0;
        case (x.op)
            OP_AND: r = a & b;
            OP_EOR: r = a ^ b;
            OP_LSL: begin
                if (amt == 0) begin
                    r = a;
                end else if (amt < 32) begin
                    r = a << amt;
                    c = a[32 - amt];
                end else if (amt == 32) begin
                    r = '0;
                    c = a[0];
                end else begin
                    r = '0;
                    c = 1'b0;
                end
            end
            OP_LSR: begin
                if (amt == 0) begin
                    r = a;
                end else if (amt < 32) begin
                    r = a >> amt;
                    c = a[amt - 1];
                end else if (amt == 32) begin
                    r = '0;
                    c = a[31];
                end else begin
                    r = '0;
                    c = 1'b0;
                end
            end
            OP_ASR: begin
                if (amt == 0) begin
                    r = a;
                end else if (amt < 32) begin
                    r = $signed(a) >>> amt;
                    c = a[amt - 1];
                end else begin
                    r = {32{a[31]}};
                    c = a[31];
                end
            end
            OP_ADC: begin
                sum = add_with_carry(a, b, c);
                {v, c, r} = sum;
            end
            OP_SBC: begin
                sum = add_with_carry(a, ~b, c);
                {v, c, r} = sum;
            end
            OP_ROR: begin
                rot = amt[4:0];
                if (amt == 0) begin
                    r = a;
                end else if (rot == 0) begin
                    r = a;
                    c = a[31];
                end else begin
                    r = (a >> rot) | (a << (32 - rot));
                    c = a[rot - 1];
                end
            end
            OP_TST: begin
                r  = a & b;
                wb = 1'b0;
            end
            OP_NEG: begin
                r = 32'd0 - b;
                c = (b == 32'd0);
                v = (b == 32'h8000_0000);
            end
            OP_CMP: begin
                sum = add_with_carry(a, ~b, 1'b1);
                {v, c, r} = sum;
                wb = 1'b0;
            end
            OP_CMN: begin
                sum = add_with_carry(a, b, 1'b0);
                {v, c, r} = sum;
                wb = 1'b0;
            end
            OP_ORR: r = a | b;
            OP_MUL: r = a * b;
            OP_BIC: r = a & ~b;
            OP_MVN: r = ~b;
        endcase
        o.result        = r;
        o.write_back    = wb;
        o.flag_negative = r[31];
        o.flag_zero     = (r == 32'd0);
        o.flag_carry    = c;
        o.flag_overflow = v;
        return o;
    endfunction

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 7))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            4: return $urandom_range(0, 15);
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [7:0] pick_shift_amount();
        case ($urandom_range(0, 7))
            0: return 8'd0;
            1: return 8'd32;
            2: return 8'd255;
            3: return 8'($urandom_range(33, 64));
            4: return 8'($urandom());
            default: return 8'($urandom_range(1, 31));
        endcase
    endfunction

    task automatic queue_op(t_alu_op op, logic [31:0] a, logic [31:0] b, logic c, logic v,
                            int unsigned gap, bit drain);
        t_alu_request req;
        req.operands.op           = op;
        req.operands.dest_value   = a;
        req.operands.source_value = b;
        req.operands.carry_in     = c;
        req.operands.overflow_in  = v;
        req.gap                   = gap;
        req.drain                 = drain;
        pending_q.push_back(req);
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %h, actual %h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    always @(posedge i_clk) begin
        bit go;
        go = 1'b0;
        if (!i_rst_n) begin
            u_in_if.valid <= 1'b0;
        end else if (!u_in_if.valid || u_in_if.ready) begin
            if (u_in_if.valid) begin
                alu_results_due.push_back(execute_alu_op(in_flight));
                ops_seen[in_flight.op] = 1'b1;
                transfers_in++;
            end
            if (!have_staged && pending_q.size() != 0) begin
                staged      = pending_q.pop_front();
                have_staged = 1'b1;
            end
            if (have_staged && staged.gap != 0) begin
                staged.gap--;
            end else if (have_staged && !(staged.drain && alu_results_due.size() != 0)) begin
                go = 1'b1;
            end
            if (go) begin
                in_flight                <= staged.operands;
                u_in_if.operation        <= staged.operands.op;
                u_in_if.dest_value       <= staged.operands.dest_value;
                u_in_if.source_value     <= staged.operands.source_value;
                u_in_if.carry_in         <= staged.operands.carry_in;
                u_in_if.overflow_in      <= staged.operands.overflow_in;
                have_staged = 1'b0;
            end
            u_in_if.valid <= go;
        end
    end

    always @(posedge i_clk) begin
        t_alu_out want;
        bit       quiet;
        if (!i_rst_n) begin
            u_out_if.ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (u_out_if.valid && u_out_if.ready) begin
                if (alu_results_due.size() == 0) begin
                    $error("result transfer with nothing outstanding: result %h",
                           u_out_if.result);
                    fail_count++;
                end else begin
                    want = alu_results_due.pop_front();
                    check_field("result", want.result, u_out_if.result);
                    check_field("write_back", 32'(want.write_back),
                                32'(u_out_if.write_back));
                    check_field("flag_negative", 32'(want.flag_negative),
                                32'(u_out_if.flag_negative));
                    check_field("flag_zero", 32'(want.flag_zero), 32'(u_out_if.flag_zero));
                    check_field("flag_carry", 32'(want.flag_carry), 32'(u_out_if.flag_carry));
                    check_field("flag_overflow", 32'(want.flag_overflow),
                                32'(u_out_if.flag_overflow));
                    results_checked++;
                end
            end
            if (cycle_count % 256 == 0) begin
                stall_mode = $urandom_range(0, 2);
            end
            quiet = (pending_q.size() <= TAIL_ITEMS) || (stall_mode == 0);
            if (stall_left != 0) begin
                stall_left--;
                u_out_if.ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, stall_mode == 1 ? 11 : 3) == 0) begin
                stall_left = $urandom_range(1, 15) - 1;
                u_out_if.ready <= 1'b0;
            end else begin
                u_out_if.ready <= 1'b1;
            end
        end
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles", cycle_count);
        $display("thumb_alu_register_ops_unit verification failed");
        $finish;
    end

    initial begin
        int unsigned seg_mode;
        int unsigned gap;
        int unsigned total_items;
        t_alu_op     op;
        logic [31:0] a;
        logic [31:0] b;

        i_rst_n                = 1'b0;
        u_in_if.valid          = 1'b0;
        u_in_if.operation      = '0;
        u_in_if.dest_value     = '0;
        u_in_if.source_value   = '0;
        u_in_if.carry_in       = 1'b0;
        u_in_if.overflow_in    = 1'b0;
        u_out_if.ready         = 1'b0;
        seg_mode               = 0;

        queue_op(OP_AND, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b1, 0, 1'b0);
        queue_op(OP_EOR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0, 0, 1'b0);
        queue_op(OP_LSL, 32'h8000_0001, 32'hFFFF_FF00, 1'b1, 1'b1, 0, 1'b0);
        queue_op(OP_LSL, 32'h8000_0001, 32'h0000_0001, 1'b0, 1'b0, 0, 1'b0);
        queue_op(OP_LSL, 32'h0000_0001, 32'h0000_0020, 1'b0, 1'b1, 0, 1'b0);
        queue_op(OP_LSL, 32'hFFFF_FFFF, 32'hFFFF_FF21, 1'b1, 1'b0, 0, 1'b0);
        queue_op(OP_LSR, 32'h8000_0000, 32'h0000_0020, 1'b0, 1'b0, 0, 1'b0);
        queue_op(OP_LSR, 32'hFFFF_FFFF, 32'h0000_00FF, 1'b1, 1'b1, 0, 1'b0);
        queue_op(OP_LSR, 32'h0000_0003, 32'h0000_0001, 1'b0, 1'b0, 0, 1'b0);
        queue_op(OP_ASR, 32'h8000_0000, 32'h0000_0020, 1'b0, 1'b0, 0, 1'b0);
        queue_op(OP_ASR, 32'h8000_0000, 32'h0000_001F, 1'b0, 1'b1, 0, 1'b0);
        queue_op(OP_ASR, 32'h7FFF_FFFF, 32'h0000_00FF, 1'b1, 1'b0, 0, 1'b0);
        queue_op(OP_ADC, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1, 1'b0, 0, 1'b0);
        queue_op(OP_ADC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, 0, 1'b0);
        queue_op(OP_SBC, 32'h8000_0000, 32'h0000_0000, 1'b0, 1'b0, 0, 1'b0);
        queue_op(OP_ROR, 32'h8000_0001, 32'h0000_0000, 1'b0, 1'b1, 0, 1'b0);
        queue_op(OP_ROR, 32'h8000_0001, 32'h0000_0040, 1'b0, 1'b0, 0, 1'b0);
        queue_op(OP_ROR, 32'h0000_0010, 32'h0000_0025, 1'b1, 1'b0, 0, 1'b0);
        queue_op(OP_TST, 32'h0F0F_0F0F, 32'hF0F0_F0F0, 1'b1, 1'b1, 0, 1'b0);
        queue_op(OP_NEG, 32'h1234_5678, 32'h0000_0000, 1'b0, 1'b1, 0, 1'b0);
        queue_op(OP_NEG, 32'h0000_0000, 32'h8000_0000, 1'b1, 1'b0, 0, 1'b0);
        queue_op(OP_CMP, 32'h8000_0000, 32'h0000_0001, 1'b0, 1'b0, 0, 1'b0);
        queue_op(OP_CMN, 32'hFFFF_FFFF, 32'h0000_0001, 1'b0, 1'b1, 0, 1'b0);
        queue_op(OP_ORR, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, 0, 1'b0);
        queue_op(OP_MUL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 0, 1'b0);
        queue_op(OP_BIC, 32'hFFFF_FFFF, 32'h5555_AAAA, 1'b0, 1'b0, 0, 1'b0);
        queue_op(OP_MVN, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1, 0, 1'b0);

        for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 64 == 0) begin
                seg_mode = $urandom_range(0, 2);
            end
            op = t_alu_op'($urandom_range(0, 15));
            a  = pick_operand();
            b  = pick_operand();
            if (op inside {OP_LSL, OP_LSR, OP_ASR, OP_ROR} && $urandom_range(0, 3) != 0) begin
                b[7:0] = pick_shift_amount();
            end else if (op inside {OP_ADC, OP_SBC, OP_CMP, OP_CMN}
                         && $urandom_range(0, 7) == 0) begin
                b = a;
            end
            gap = 0;
            if (i < RANDOM_ITEMS - TAIL_ITEMS && seg_mode != 0
                && $urandom_range(0, seg_mode == 1 ? 11 : 2) == 0) begin
                gap = $urandom_range(1, 15);
            end
            queue_op(op, a, b, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), gap,
                     i % DRAIN_EVERY == 0);
        end
        total_items = pending_q.size();

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (transfers_in < total_items) @(posedge i_clk);
        while (alu_results_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("%0d operand transfers, %0d results checked, %0d of 16 operations exercised",
                 transfers_in, results_checked, $countones(ops_seen));
        $display("shift amounts 0, 1-31, 32, above 32 and 255; idle and stall bursts 1-15");
        if (fail_count == 0) begin
            $display("thumb_alu_register_ops_unit verification clean");
        end else begin
            $display("thumb_alu_register_ops_unit verification failed");
        end
        $finish;
    end

endmodule
